### rtl/core/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, constants and decode helpers for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_UNKNOWN_ESC = 2'd1,
    ERR_BAD_HEX     = 2'd2,
    ERR_END_IN_ESC  = 2'd3
  } jsu_err_e;

  localparam logic [7:0] CharBackslash = 8'h5c;
  localparam logic [7:0] CharU         = 8'h75;

  localparam logic [15:0] OneByteMax = 16'h007f;
  localparam logic [15:0] TwoByteMax = 16'h07ff;
  localparam logic [7:0]  Lead2      = 8'hc0;
  localparam logic [7:0]  Lead3      = 8'he0;
  localparam logic [7:0]  ContMark   = 8'h80;
  localparam logic [5:0]  ContMask   = 6'h3f;

  // up to three decoded bytes produced by one input beat
  typedef struct packed {
    logic [1:0]      last_idx;
    logic [2:0][7:0] bytes;
    logic            eos;
    jsu_err_e        err;
  } jsu_job_t;

  // {valid, value}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // {valid, byte}
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'h22:   r = {1'b1, 8'h22};
      8'h5c:   r = {1'b1, 8'h5c};
      8'h2f:   r = {1'b1, 8'h2f};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0c};
      8'h6e:   r = {1'b1, 8'h0a};
      8'h72:   r = {1'b1, 8'h0d};
      8'h74:   r = {1'b1, 8'h09};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Accepts raw string bytes, tracks escape state and builds decoded jobs.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              final_byte_i,
  input  logic              q_full_i,
  output logic              push_o,
  output jsu_pkg::jsu_job_t job_o
);
  import jsu_pkg::*;

  typedef enum logic [1:0] {
    PH_PLAIN  = 2'd0,
    PH_ESCAPE = 2'd1,
    PH_HEX    = 2'd2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  hex_cnt_q, hex_cnt_d;
  logic [15:0] acc_q, acc_d;
  jsu_err_e    err_q, err_d;

  logic        accept;
  logic        job_valid;
  jsu_job_t    job;
  logic [4:0]  hex;
  logic [8:0]  esc;
  logic [15:0] cp;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign hex        = hex_value(in_byte_i);
  assign esc        = simple_escape(in_byte_i);
  assign cp         = {acc_q[11:0], hex[3:0]};

  always_comb begin
    phase_d   = phase_q;
    hex_cnt_d = hex_cnt_q;
    acc_d     = acc_q;
    err_d     = err_q;
    job_valid = 1'b0;
    job       = '{last_idx: 2'd0, bytes: '0, eos: final_byte_i, err: ERR_NONE};
    if (err_q == ERR_NONE) begin
      case (phase_q)
        PH_ESCAPE: begin
          if (esc[8]) begin
            job_valid     = 1'b1;
            job.bytes[0]  = esc[7:0];
            phase_d       = PH_PLAIN;
          end else if (in_byte_i == CharU) begin
            phase_d   = PH_HEX;
            hex_cnt_d = 2'd0;
            acc_d     = 16'd0;
            if (final_byte_i) err_d = ERR_END_IN_ESC;
          end else begin
            err_d = ERR_UNKNOWN_ESC;
          end
        end
        PH_HEX: begin
          if (!hex[4]) begin
            err_d = ERR_BAD_HEX;
          end else if (hex_cnt_q == 2'd3) begin
            job_valid = 1'b1;
            if (cp <= OneByteMax) begin
              job.bytes[0] = cp[7:0];
            end else if (cp <= TwoByteMax) begin
              job.last_idx = 2'd1;
              job.bytes[0] = Lead2 | {3'd0, cp[10:6]};
              job.bytes[1] = ContMark | {2'd0, cp[5:0] & ContMask};
            end else begin
              job.last_idx = 2'd2;
              job.bytes[0] = Lead3 | {4'd0, cp[15:12]};
              job.bytes[1] = ContMark | {2'd0, cp[11:6] & ContMask};
              job.bytes[2] = ContMark | {2'd0, cp[5:0] & ContMask};
            end
            phase_d   = PH_PLAIN;
            hex_cnt_d = 2'd0;
            acc_d     = 16'd0;
          end else begin
            acc_d     = cp;
            hex_cnt_d = hex_cnt_q + 2'd1;
            if (final_byte_i) err_d = ERR_END_IN_ESC;
          end
        end
        default: begin
          phase_d = PH_PLAIN;
          if (in_byte_i == CharBackslash) begin
            phase_d = PH_ESCAPE;
            if (final_byte_i) err_d = ERR_END_IN_ESC;
          end else begin
            job_valid    = 1'b1;
            job.bytes[0] = in_byte_i;
          end
        end
      endcase
    end
    if (err_d != ERR_NONE) begin
      job_valid = final_byte_i;
      job       = '{last_idx: 2'd0, bytes: '0, eos: 1'b1, err: err_d};
    end
    if (final_byte_i) begin
      phase_d   = PH_PLAIN;
      hex_cnt_d = 2'd0;
      acc_d     = 16'd0;
      err_d     = ERR_NONE;
    end
  end

  assign push_o = accept && job_valid;
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_PLAIN;
      hex_cnt_q <= 2'd0;
      acc_q     <= 16'd0;
      err_q     <= ERR_NONE;
    end else if (accept) begin
      phase_q   <= phase_d;
      hex_cnt_q <= hex_cnt_d;
      acc_q     <= acc_d;
      err_q     <= err_d;
    end
  end

endmodule

### rtl/core/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Small job queue between the decoder front and the byte serializer.
// ----------------------------------------------------------------------------
module jsu_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  jsu_pkg::jsu_job_t wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output jsu_pkg::jsu_job_t rdata_o
);
  import jsu_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  jsu_job_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

### rtl/core/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Serializes queued jobs into single output beats through an output register.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  jsu_pkg::jsu_job_t job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              end_of_string_o,
  output logic [1:0]        error_code_o
);
  import jsu_pkg::*;

  logic       out_valid_q;
  logic [7:0] byte_q;
  logic       eos_q;
  jsu_err_e   err_q;
  logic [1:0] idx_q;
  logic       load, take, last;

  assign load = !out_valid_q || out_ready_i;
  assign take = load && q_valid_i;
  assign last = (idx_q == job_i.last_idx);
  assign pop_o = take && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      if (load) out_valid_q <= q_valid_i;
      if (take) idx_q <= last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= job_i.bytes[idx_q];
      eos_q  <= job_i.eos && last;
      err_q  <= job_i.err;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = byte_q;
  assign end_of_string_o = eos_q;
  assign error_code_o    = err_q;

endmodule

### rtl/core/json_string_unescape.sv
// ----------------------------------------------------------------------------
// json_string_unescape
// Streaming decoder for the body of a JSON string, escapes to bytes/UTF-8.
// ----------------------------------------------------------------------------
// usage:
//   input beats carry one raw byte of a string body; final_byte_i marks the
//   last byte of each string. output beats carry one decoded byte each, with
//   end_of_string_o on the last beat of the string. a \uXXXX escape gives one
//   to three UTF-8 beats. on an error the rest of the string is dropped and
//   its final byte gives one beat with error_code_o set and end_of_string_o
//   high; beats already delivered for that string must be discarded.
// timing:
//   an accepted byte's job is queued, then loaded into the output register.
//   input is taken every cycle while the job queue has room; output runs
//   one beat per cycle while out_ready_i is high, so a u escape needs up
//   to three output beats. the queue (QUEUE_DEPTH jobs) absorbs these bursts.
// reset:
//   clears escape state, the queue and the output valid flag.
// stall:
//   when out_ready_i stays low the output beat holds, the queue fills, and
//   then in_ready_o drops until beats drain.
// ----------------------------------------------------------------------------
module json_string_unescape #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       end_of_string_o,
  output logic [1:0] error_code_o
);
  import jsu_pkg::*;

  logic     q_full, q_valid, push, pop;
  jsu_job_t wjob, rjob;

  jsu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .final_byte_i (final_byte_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .job_o        (wjob)
  );

  jsu_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wjob),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (rjob)
  );

  jsu_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .job_i           (rjob),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .end_of_string_o (end_of_string_o),
    .error_code_o    (error_code_o)
  );

endmodule
